[rtl/core/kl_pkg.sv]
// Package for the keyed list table: sizes, operation and status codes,
// controller states and the control word broadcast to the row of cells.
// No dependencies.
`timescale 1ns / 1ps

package kl_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  // field widths
  localparam int KEYW = 32;
  localparam int OPW  = 3;
  localparam int STW  = 3;
  localparam int POSW = 6;

  // operation codes
  localparam logic [OPW-1:0] OP_APPEND = 3'd0;
  localparam logic [OPW-1:0] OP_FIND   = 3'd1;
  localparam logic [OPW-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPW-1:0] OP_SORT   = 3'd3;
  localparam logic [OPW-1:0] OP_DUMP   = 3'd4;

  // status codes
  localparam logic [STW-1:0] STAT_OK        = 3'd0;
  localparam logic [STW-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STW-1:0] STAT_BAD_INDEX = 3'd2;
  localparam logic [STW-1:0] STAT_FULL      = 3'd3;
  localparam logic [STW-1:0] STAT_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_SORT,
    ST_DUMP
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_REMOVE,
    CMD_ROTATE,
    CMD_SORT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic signed [KEYW-1:0] key;
    logic [IDXW-1:0]        slot;
    logic [CNTW-1:0]        count;
    logic                   phase_odd;
    logic                   descending;
  } cell_ctl_t;

endpackage

[rtl/core/kl_cell.sv]
// One cell of the key row: holds a single key, loads it from ctl and
// trades it with neighbours for removal, rotation and odd-even sort steps.
// Depends on kl_pkg.
`timescale 1ns / 1ps

module kl_cell (
  input  logic                           clk,
  input  kl_pkg::cell_ctl_t              ctl,
  input  logic [kl_pkg::IDXW-1:0]        pos,
  input  logic signed [kl_pkg::KEYW-1:0] left_key,
  input  logic                           left_swap,
  input  logic signed [kl_pkg::KEYW-1:0] right_key,
  output logic signed [kl_pkg::KEYW-1:0] key,
  output logic                           swap
);

  logic [kl_pkg::CNTW-1:0] pos_ext;
  logic                    leader;
  logic                    out_of_order;

  assign pos_ext = kl_pkg::CNTW'(pos);

  // lead a compare-exchange with the right neighbour on this phase
  assign leader = (pos[0] == ctl.phase_odd) &&
                  ((pos_ext + kl_pkg::CNTW'(1)) < ctl.count);
  assign out_of_order = ctl.descending ? (key < right_key) : (right_key < key);
  assign swap = leader && out_of_order;

  // update the held key
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      kl_pkg::CMD_LOAD: begin
        if (pos == ctl.slot) key <= ctl.key;
      end
      kl_pkg::CMD_REMOVE: begin
        if (pos >= ctl.slot) key <= right_key;
      end
      kl_pkg::CMD_ROTATE: begin
        key <= right_key;
      end
      kl_pkg::CMD_SORT: begin
        if (swap) key <= right_key;
        else if (left_swap) key <= left_key;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/kl_ctrl.sv]
// Controller of the key row: takes transactions, sequences find, sort and
// dump over the ring of cells and holds the result register.
// Depends on kl_pkg.
`timescale 1ns / 1ps

module kl_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kl_pkg::OPW-1:0]         op,
  input  logic signed [kl_pkg::KEYW-1:0] key_in,
  input  logic [kl_pkg::POSW-1:0]        index_in,
  input  logic                           descending,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kl_pkg::STW-1:0]         status,
  output logic [kl_pkg::POSW-1:0]        index_out,
  output logic signed [kl_pkg::KEYW-1:0] key_out,
  output logic                           last,
  input  logic signed [kl_pkg::KEYW-1:0] head_key,
  output kl_pkg::cell_ctl_t              ctl
);

  kl_pkg::state_t                 state, state_next;
  logic [kl_pkg::CNTW-1:0]        count, count_next;
  logic [kl_pkg::IDXW-1:0]        step, step_next;
  logic                           found, found_next;
  logic [kl_pkg::IDXW-1:0]        found_idx, found_idx_next;
  logic signed [kl_pkg::KEYW-1:0] mkey, mkey_next;
  logic                           desc, desc_next;

  logic                           out_free;
  logic                           accept;
  logic                           step_last;
  logic                           step_in;
  logic                           hit;
  logic                           emit;
  logic [kl_pkg::STW-1:0]         e_status;
  logic [kl_pkg::POSW-1:0]        e_idx;
  logic signed [kl_pkg::KEYW-1:0] e_key;
  logic                           e_last;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == kl_pkg::ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign step_last = (step == kl_pkg::IDXW'(kl_pkg::DEPTH - 1));
  assign step_in   = kl_pkg::CNTW'(step) < count;
  assign hit       = step_in && !found && (head_key == mkey);

  // next state, cell command and result
  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    found_next     = found;
    found_idx_next = found_idx;
    mkey_next      = mkey;
    desc_next      = desc;
    emit           = 1'b0;
    e_status       = kl_pkg::STAT_OK;
    e_idx          = '0;
    e_key          = '0;
    e_last         = 1'b1;
    ctl.cmd        = kl_pkg::CMD_HOLD;
    ctl.key        = key_in;
    ctl.slot       = count[kl_pkg::IDXW-1:0];
    ctl.count      = count;
    ctl.phase_odd  = step[0];
    ctl.descending = desc;

    case (state)
      kl_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            kl_pkg::OP_APPEND: begin
              emit = 1'b1;
              if (count == kl_pkg::CNTW'(kl_pkg::DEPTH)) begin
                e_status = kl_pkg::STAT_FULL;
              end else begin
                ctl.cmd    = kl_pkg::CMD_LOAD;
                count_next = count + kl_pkg::CNTW'(1);
              end
            end
            kl_pkg::OP_FIND: begin
              mkey_next  = key_in;
              found_next = 1'b0;
              step_next  = '0;
              state_next = kl_pkg::ST_FIND;
            end
            kl_pkg::OP_REMOVE: begin
              emit = 1'b1;
              if (7'(index_in) >= 7'(count)) begin
                e_status = kl_pkg::STAT_BAD_INDEX;
              end else begin
                ctl.cmd    = kl_pkg::CMD_REMOVE;
                ctl.slot   = index_in[kl_pkg::IDXW-1:0];
                count_next = count - kl_pkg::CNTW'(1);
              end
            end
            kl_pkg::OP_SORT: begin
              desc_next  = descending;
              step_next  = '0;
              state_next = kl_pkg::ST_SORT;
            end
            kl_pkg::OP_DUMP: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = kl_pkg::STAT_EMPTY;
              end else begin
                step_next  = '0;
                state_next = kl_pkg::ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // rotate the ring once per cycle, unless a stalled output holds the last step, and watch the head cell
      kl_pkg::ST_FIND: begin
        if (!step_last || out_free) begin
          ctl.cmd   = kl_pkg::CMD_ROTATE;
          step_next = step + kl_pkg::IDXW'(1);
          if (hit) begin
            found_next     = 1'b1;
            found_idx_next = step;
          end
          if (step_last) begin
            emit       = 1'b1;
            state_next = kl_pkg::ST_IDLE;
            if (found) begin
              e_idx = kl_pkg::POSW'(found_idx);
            end else if (hit) begin
              e_idx = kl_pkg::POSW'(step);
            end else begin
              e_status = kl_pkg::STAT_NOT_FOUND;
            end
          end
        end
      end

      // one odd-even transposition phase per cycle, unless a stalled output holds the last phase
      kl_pkg::ST_SORT: begin
        if (!step_last || out_free) begin
          ctl.cmd   = kl_pkg::CMD_SORT;
          step_next = step + kl_pkg::IDXW'(1);
          if (step_last) begin
            emit       = 1'b1;
            state_next = kl_pkg::ST_IDLE;
          end
        end
      end

      // emit the head cell while it holds a stored key, then rotate
      kl_pkg::ST_DUMP: begin
        if (!step_in || out_free) begin
          ctl.cmd   = kl_pkg::CMD_ROTATE;
          step_next = step + kl_pkg::IDXW'(1);
          if (step_in) begin
            emit   = 1'b1;
            e_idx  = kl_pkg::POSW'(step);
            e_key  = head_key;
            e_last = (kl_pkg::CNTW'(step) + kl_pkg::CNTW'(1)) == count;
          end
          if (step_last) state_next = kl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = kl_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kl_pkg::ST_IDLE;
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    step      <= step_next;
    found_idx <= found_idx_next;
    mkey      <= mkey_next;
    desc      <= desc_next;
    if (emit) begin
      status    <= e_status;
      index_out <= e_idx;
      key_out   <= e_key;
      last      <= e_last;
    end
  end

endmodule

[rtl/core/keyed_list_table.sv]
// Keyed list table: append, remove and the full, bad-index and empty-dump
// answers are registered and show in the cycle after acceptance; find and
// sort walk the whole ring and answer after its last step; dump shows the
// stored keys in position order. Short operations take one transaction
// per cycle while out_stall is low; find, sort and dump stall input until done.
// Reset clears the key count and control state; stored keys are not cleared.
`timescale 1ns / 1ps

module keyed_list_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kl_pkg::OPW-1:0]         op,
  input  logic signed [kl_pkg::KEYW-1:0] key_in,
  input  logic [kl_pkg::POSW-1:0]        index_in,
  input  logic                           descending,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kl_pkg::STW-1:0]         status,
  output logic [kl_pkg::POSW-1:0]        index_out,
  output logic signed [kl_pkg::KEYW-1:0] key_out,
  output logic                           last
);

  kl_pkg::cell_ctl_t              ctl;
  logic signed [kl_pkg::KEYW-1:0] cell_key  [kl_pkg::DEPTH];
  logic                           cell_swap [kl_pkg::DEPTH];

  kl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .key_in     (key_in),
    .index_in   (index_in),
    .descending (descending),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .index_out  (index_out),
    .key_out    (key_out),
    .last       (last),
    .head_key   (cell_key[0]),
    .ctl        (ctl)
  );

  // ring of cells, each wired to both neighbours
  for (genvar g = 0; g < kl_pkg::DEPTH; g++) begin : g_cell
    kl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (kl_pkg::IDXW'(g)),
      .left_key  (cell_key[(g + kl_pkg::DEPTH - 1) % kl_pkg::DEPTH]),
      .left_swap (cell_swap[(g + kl_pkg::DEPTH - 1) % kl_pkg::DEPTH]),
      .right_key (cell_key[(g + 1) % kl_pkg::DEPTH]),
      .key       (cell_key[g]),
      .swap      (cell_swap[g])
    );
  end

endmodule
